@@ rtl/gait_phase_scheduler_core_assert.svh @@
// Assertion macros for the gait phase scheduler.
`ifndef GAIT_PHASE_SCHEDULER_CORE_ASSERT_SVH
`define GAIT_PHASE_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GPS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define GPS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define GPS_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define GPS_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

@@ rtl/gps_pkg.sv @@
// Shared types and constants of the gait phase scheduler.
package gps_pkg;
  localparam int GPS_LEGS = 4;
  localparam int GPS_MAX_SEGMENTS = 16;
  localparam int GPS_FRAC_BITS = 16;
  localparam int TIME_W = 64;
  localparam int NS_W = 40;
  localparam int SEG_W = 4;
  localparam int LEG_W = 2;
  localparam int PROG_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEGS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF3 = 3'd6;

  typedef struct packed {
    logic [SEG_W-1:0]  segment_index;
    logic [LEG_W-1:0]  leg_index;
    logic              in_contact;
    logic [PROG_W-1:0] contact_progress;
    logic [PROG_W-1:0] swing_progress;
    logic              last;
  } gps_out_t;

  typedef struct packed {
    logic             kind;
    logic [TIME_W-1:0] time_ns;
  } gps_in_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SINGLE, OP_TIME, OP_OFFSET, OP_CUR, OP_PHASE, OP_FRAC, OP_NEXT
  } gps_op_t;

  typedef struct packed {
    gps_op_t op;
    logic    start;
  } gps_cmd_t;

  typedef struct packed {
    logic busy;
    logic last_leg;
    logic last_row;
  } gps_sts_t;
endpackage

@@ rtl/gps_if.sv @@
// Valid/ready channel carrying one payload.
interface gps_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/gps_ctrl.sv @@
// Sequencing state machine of the gait phase scheduler.
module gps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  input  gps_pkg::gps_sts_t sts,
  output gps_pkg::gps_cmd_t cmd,
  output logic          emit
);
  import gps_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_SINGLE, S_TIME, S_OFFSET, S_CUR, S_PHASE, S_FRAC, S_EMIT, S_NEXT
  } state_t;
  state_t state_r;
  logic started_r;

  assign in_ready = (state_r == S_IDLE);
  assign emit = (state_r == S_EMIT) && !out_busy;

  always_comb begin
    cmd.op = OP_NONE;
    cmd.start = !started_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_SINGLE: cmd.op = OP_SINGLE;
      S_TIME: cmd.op = OP_TIME;
      S_OFFSET: cmd.op = OP_OFFSET;
      S_CUR: cmd.op = OP_CUR;
      S_PHASE: cmd.op = OP_PHASE;
      S_FRAC: cmd.op = OP_FRAC;
      S_NEXT: cmd.op = OP_NEXT;
      default: cmd.op = OP_NONE;
    endcase
  end

  // Each iterating op runs while sts.busy; started_r is clear in its first cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      started_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          started_r <= 1'b0;
          if (in_valid) state_r <= S_SINGLE;
        end
        S_SINGLE, S_TIME, S_OFFSET, S_CUR, S_FRAC: begin
          if (!started_r) started_r <= 1'b1;
          else if (!sts.busy) begin
            started_r <= 1'b0;
            case (state_r)
              S_SINGLE: state_r <= S_TIME;
              S_TIME: state_r <= S_OFFSET;
              S_OFFSET: state_r <= S_CUR;
              S_CUR: state_r <= S_PHASE;
              default: state_r <= S_EMIT;
            endcase
          end
        end
        S_PHASE: state_r <= S_FRAC;
        S_EMIT: begin
          if (!out_busy) state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (sts.last_leg && sts.last_row) state_r <= S_IDLE;
          else if (sts.last_leg) state_r <= S_TIME;
          else state_r <= S_OFFSET;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/gps_dp.sv @@
// Datapath: configuration, shared restoring divider and result fields.
module gps_dp #(
  parameter int LEGS = gps_pkg::GPS_LEGS,
  parameter int MAX_SEGMENTS = gps_pkg::GPS_MAX_SEGMENTS,
  parameter int PROGRESS_FRACTION_BITS = gps_pkg::GPS_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  gps_pkg::gps_in_t               in_item,
  input  gps_pkg::gps_cmd_t              cmd,
  output gps_pkg::gps_sts_t              sts,
  output gps_pkg::gps_out_t              result
);
  import gps_pkg::*;
  localparam int SW = $clog2(MAX_SEGMENTS + 1);
  localparam int RW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int LW = (LEGS > 1) ? $clog2(LEGS) : 1;
  localparam int CW = $clog2(TIME_W + 1);
  localparam int PW = PROGRESS_FRACTION_BITS + 1;

  logic [NS_W-1:0] period_r, contact_r;
  logic [4:0] segs_r;
  logic [SEG_W-1:0] off_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= NS_W'(64'd1000000000);
      contact_r <= NS_W'(64'd500000000);
      segs_r <= 5'd10;
      off_r[0] <= 4'd0; off_r[1] <= 4'd5; off_r[2] <= 4'd5; off_r[3] <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: period_r <= cfg_data;
        REG_CONTACT: contact_r <= cfg_data;
        REG_SEGS: segs_r <= cfg_data[4:0];
        default: begin
          if (cfg_index >= REG_OFF0 && cfg_index <= REG_OFF3)
            off_r[2'(cfg_index - REG_OFF0)] <= cfg_data[3:0];
        end
      endcase
    end
  end

  logic [NS_W-1:0] period, swing;
  logic [SW-1:0] segs;
  always_comb begin
    period = (period_r == '0) ? NS_W'(1) : period_r;
    swing = (contact_r < period) ? period - contact_r : '0;
    if (segs_r == 5'd0) segs = SW'(1);
    else if (32'(segs_r) > MAX_SEGMENTS) segs = SW'(MAX_SEGMENTS);
    else segs = SW'(segs_r);
  end

  logic kind_r;
  logic [TIME_W-1:0] tcur_r;
  logic [NS_W-1:0] single_r, offm_r, cur_r, norm_r, fden_r;
  logic [RW-1:0] row_r;
  logic [LW-1:0] leg_r;
  logic stance_r, full_r;

  // Shared restoring divider: remainder r, quotient q, one bit a cycle.
  logic [TIME_W-1:0] dnum_r, q_r;
  logic [NS_W:0] rem_r;
  logic [NS_W-1:0] dden_r;
  logic [CW-1:0] cnt_r;
  logic [NS_W:0] rsh;
  logic [NS_W:0] rdiff;
  logic rge;
  always_comb begin
    rsh = {rem_r[NS_W-1:0], dnum_r[TIME_W-1]};
    rge = rsh >= {1'b0, dden_r};
    rdiff = rsh - {1'b0, dden_r};
  end
  assign sts.busy = (cnt_r != '0);
  assign sts.last_leg = (32'(leg_r) == LEGS - 1);
  assign sts.last_row = !kind_r || (32'(row_r) + 1 == 32'(segs));

  logic [SEG_W-1:0] offsel;
  logic [NS_W+SEG_W-1:0] offmul;
  logic [NS_W:0] fracnum;
  always_comb begin
    offsel = off_r[2'(leg_r)];
    offmul = offsel * single_r;
    fracnum = stance_r ? {1'b0, norm_r} : {1'b0, norm_r} - {1'b0, contact_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        dnum_r <= {dnum_r[TIME_W-2:0], 1'b0};
        rem_r <= rge ? rdiff : rsh;
        q_r <= {q_r[TIME_W-2:0], rge};
      end
      case (cmd.op)
        OP_LOAD: begin
          kind_r <= in_item.kind;
          tcur_r <= in_item.time_ns;
          row_r <= '0;
          leg_r <= '0;
        end
        OP_SINGLE: if (cmd.start) begin
          dnum_r <= {24'd0, period}; dden_r <= NS_W'(segs);
          rem_r <= '0; cnt_r <= CW'(TIME_W);
        end else if (cnt_r == '0) single_r <= q_r[NS_W-1:0];
        OP_TIME: if (cmd.start) begin
          dnum_r <= tcur_r; dden_r <= period;
          rem_r <= '0; cnt_r <= CW'(TIME_W);
        end else if (cnt_r == '0) cur_r <= rem_r[NS_W-1:0];
        OP_OFFSET: if (cmd.start) begin
          dnum_r <= TIME_W'(offmul) << (TIME_W - NS_W - SEG_W);
          dden_r <= period; rem_r <= '0; cnt_r <= CW'(NS_W + SEG_W);
        end else if (cnt_r == '0) offm_r <= rem_r[NS_W-1:0];
        OP_CUR: if (cmd.start) begin
          cnt_r <= '0;
        end
        OP_PHASE: begin
          norm_r <= (cur_r > offm_r) ? cur_r - offm_r : period - (offm_r - cur_r);
          stance_r <= ((cur_r > offm_r) ? cur_r - offm_r : period - (offm_r - cur_r))
                      <= contact_r;
        end
        OP_FRAC: if (cmd.start) begin
          fden_r <= stance_r ? contact_r : swing;
          full_r <= (stance_r ? contact_r : swing) == '0 ? 1'b0 :
                    fracnum >= {1'b0, (stance_r ? contact_r : swing)};
          dnum_r <= '0; dden_r <= stance_r ? contact_r : swing;
          rem_r <= fracnum; q_r <= '0;
          cnt_r <= ((stance_r ? contact_r : swing) == '0) ? '0 :
                   CW'(PROGRESS_FRACTION_BITS);
        end
        OP_NEXT: begin
          if (sts.last_leg) begin
            leg_r <= '0;
            row_r <= row_r + RW'(1);
            tcur_r <= tcur_r + TIME_W'(single_r);
          end else leg_r <= leg_r + LW'(1);
        end
        default: ;
      endcase
    end
  end

  logic [PW-1:0] prog;
  always_comb begin
    if (fden_r == '0) prog = '0;
    else if (full_r) prog = PW'(1) << PROGRESS_FRACTION_BITS;
    else prog = q_r[PW-1:0];
    result.segment_index = SEG_W'(row_r);
    result.leg_index = LEG_W'(leg_r);
    result.in_contact = stance_r;
    result.contact_progress = stance_r ? PROG_W'(prog) : '0;
    result.swing_progress = stance_r ? '0 : PROG_W'(prog);
    result.last = sts.last_leg && sts.last_row;
  end
endmodule

@@ rtl/gait_phase_scheduler_core.sv @@
// Top level of the gait phase scheduler.
//  channel | dir | payload
//  in_     | in  | kind, time_ns
//  out_    | out | segment_index, leg_index, in_contact, progress, last
//  cfg_    | in  | we, index, data (40 bit)
// Each input is taken and its segment length formed; then per table row the time
// mod period, then per result the offset mod period, phase and progress
// quotient; kind 0 yields a single row, kind 1 a table of up to sixteen rows.
// Reset is synchronous; an item is taken only when idle; a stalled output holds
// the sequencer in its emit state.
`include "gait_phase_scheduler_core_assert.svh"
module gait_phase_scheduler_core #(
  parameter int LEGS = gps_pkg::GPS_LEGS,
  parameter int MAX_SEGMENTS = gps_pkg::GPS_MAX_SEGMENTS,
  parameter int PROGRESS_FRACTION_BITS = gps_pkg::GPS_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data,
  gps_if.sink                            in_ch,
  gps_if.source                          out_ch
);
  import gps_pkg::*;
  gps_cmd_t cmd;
  gps_sts_t sts;
  gps_out_t res;
  logic emit, out_valid_r;
  gps_out_t out_r;

  gps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_valid_r && !out_ch.ready), .sts, .cmd, .emit
  );
  gps_dp #(.LEGS(LEGS), .MAX_SEGMENTS(MAX_SEGMENTS),
           .PROGRESS_FRACTION_BITS(PROGRESS_FRACTION_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_item(in_ch.data),
    .cmd, .sts, .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (emit) out_r <= res;
  end
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  `GPS_ASSERT_IMP(a_no_overwrite, clk, rst_n, emit, !out_valid_r || out_ch.ready, "result overwritten")
  `GPS_ASSERT_NXT(a_emit_valid, clk, rst_n, emit, out_valid_r, "emitted result not shown")
  `GPS_ASSERT_IMP(a_idle_take, clk, rst_n, in_ch.valid && in_ch.ready, cmd.op == OP_LOAD, "take without load")
endmodule
